FILE: rtl/core/mlfq_pkg.sv
package mlfq_pkg;

  localparam int LEVELS = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int PROCESS_SLOTS = 16;
  localparam int LVL_W = $clog2(LEVELS);
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PID_W = $clog2(PROCESS_SLOTS);
  localparam int QADDR_W = LVL_W + QPTR_W;
  localparam int FIFO_DEPTH = 2;
  localparam int NUM_CFG = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] SLICE_RESET [NUM_CFG] = '{8'd1, 8'd2, 8'd4, 8'd8};

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  new_id;
    logic [15:0] service_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        ran_valid;
    logic [3:0]  ran_id;
    logic [1:0]  ran_level;
    logic        completed;
    logic [31:0] finish_time;
    logic        preempted;
  } out_item_t;

  // Classified command passed from the front end to the execution unit.
  typedef struct packed {
    logic             is_tick;
    logic             reject_zero;
    logic [PID_W-1:0] pid;
    logic [15:0]      service;
  } cmd_t;

endpackage

FILE: rtl/core/mlfq_front.sv
module mlfq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mlfq_pkg::in_item_t  in_data,
  output logic                cmd_valid,
  input  logic                cmd_pop,
  output mlfq_pkg::cmd_t      cmd
);

  localparam int PW = $clog2(mlfq_pkg::FIFO_DEPTH);

  mlfq_pkg::cmd_t        fifo_r [mlfq_pkg::FIFO_DEPTH];
  logic [PW-1:0]         wp_r, rp_r;
  logic [PW:0]           cnt_r;
  logic                  push;
  mlfq_pkg::cmd_t        c;

  assign in_stall = (cnt_r == (PW+1)'(mlfq_pkg::FIFO_DEPTH));
  assign push = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign cmd = fifo_r[rp_r];

  always_comb begin
    c.is_tick = in_data.kind;
    c.reject_zero = (in_data.service_time == 16'd0);
    c.pid = in_data.new_id[mlfq_pkg::PID_W-1:0];
    c.service = in_data.service_time;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= c;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (cmd_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(cmd_pop);
    end
  end

endmodule

FILE: rtl/core/mlfq_back.sv
module mlfq_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  input  mlfq_pkg::cmd_t       cmd,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [7:0]           cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mlfq_pkg::out_item_t  out_data
);

  localparam int LW = mlfq_pkg::LVL_W;
  localparam int QW = mlfq_pkg::QPTR_W;
  localparam int CW = mlfq_pkg::QCNT_W;
  localparam int PW = mlfq_pkg::PID_W;
  localparam int AW = mlfq_pkg::QADDR_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;

  logic [7:0]       slice_r [mlfq_pkg::NUM_CFG];
  logic [QW-1:0]    head_r [mlfq_pkg::LEVELS];
  logic [CW-1:0]    count_r [mlfq_pkg::LEVELS];
  logic [7:0]       rslice_r [mlfq_pkg::PROCESS_SLOTS];
  logic [15:0]      rsvc_r [mlfq_pkg::PROCESS_SLOTS];
  logic [PW-1:0]    qmem_r [2**AW];
  logic             run_v_r;
  logic [LW-1:0]    run_lvl_r;
  logic [31:0]      time_r;
  logic [4:0]       done_cnt_r;
  mlfq_pkg::cmd_t   cmd_r;
  logic [LW-1:0]    lvl_r;
  logic             any_r;
  logic [PW-1:0]    qrd_r;
  mlfq_pkg::out_item_t out_r;
  logic             out_v_r;

  logic [LW-1:0]    sel_lvl, rd_lvl;
  logic             sel_any;
  logic             start;

  assign out_valid = out_v_r;
  assign out_data = out_r;
  assign start = (state_r == S_IDLE) && cmd_valid && !(out_v_r && out_stall);
  assign cmd_pop = start;

  always_comb begin
    sel_lvl = '0;
    sel_any = 1'b0;
    for (int i = mlfq_pkg::LEVELS - 1; i >= 0; i--) begin
      if (count_r[i] != '0) begin
        sel_lvl = LW'(i);
        sel_any = 1'b1;
      end
    end
    rd_lvl = cmd.is_tick ? sel_lvl : run_lvl_r;
  end

  // Execute-stage helpers.
  logic [PW-1:0]  p;
  logic [7:0]     sl_raw, sl_cfg, sl_eff, sl_dec;
  logic [15:0]    sv;
  logic [LW-1:0]  dst;
  logic           lvl_last;

  always_comb begin
    p = qrd_r;
    sl_raw = rslice_r[p];
    sv = rsvc_r[p];
    sl_cfg = (lvl_r < LW'(mlfq_pkg::NUM_CFG - 1)) ? slice_r[lvl_r[1:0]]
                                                  : slice_r[mlfq_pkg::NUM_CFG-1];
    if (sl_cfg == 8'd0) begin
      sl_cfg = 8'd1;
    end
    sl_eff = (sl_raw == 8'd0) ? sl_cfg : sl_raw;
    sl_dec = sl_eff - 8'd1;
    lvl_last = (lvl_r == LW'(mlfq_pkg::LEVELS - 1));
    dst = lvl_last ? lvl_r : lvl_r + 1'b1;
    if (count_r[dst] == CW'(mlfq_pkg::QUEUE_DEPTH)) begin
      dst = lvl_r;
    end
  end

  logic [CW-1:0] pos_sum;
  logic [QW-1:0] tail0;
  always_comb begin
    pos_sum = CW'(head_r[0]) + count_r[0];
    tail0 = pos_sum[QW-1:0];
  end

  // Result of the command in the execute stage.
  mlfq_pkg::out_item_t out_nxt;
  always_comb begin
    out_nxt = '0;
    if (!cmd_r.is_tick) begin
      if (cmd_r.reject_zero) begin
        out_nxt.status = mlfq_pkg::ST_ZERO;
      end else if (count_r[0] == CW'(mlfq_pkg::QUEUE_DEPTH)) begin
        out_nxt.status = mlfq_pkg::ST_FULL;
      end else begin
        out_nxt.preempted = run_v_r && (run_lvl_r != '0);
      end
    end else if (any_r) begin
      out_nxt.ran_valid = 1'b1;
      out_nxt.ran_id = 4'(p);
      out_nxt.ran_level = 2'(lvl_r);
      if (sv <= 16'd1) begin
        out_nxt.completed = 1'b1;
        out_nxt.finish_time = time_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qrd_r <= qmem_r[{rd_lvl, head_r[rd_lvl]}];
      cmd_r <= cmd;
      lvl_r <= rd_lvl;
      any_r <= sel_any;
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      run_v_r <= 1'b0;
      run_lvl_r <= '0;
      time_r <= '0;
      done_cnt_r <= '0;
      for (int i = 0; i < mlfq_pkg::NUM_CFG; i++) begin
        slice_r[i] <= mlfq_pkg::SLICE_RESET[i];
      end
      for (int i = 0; i < mlfq_pkg::LEVELS; i++) begin
        head_r[i] <= '0;
        count_r[i] <= '0;
      end
      for (int i = 0; i < mlfq_pkg::PROCESS_SLOTS; i++) begin
        rslice_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        slice_r[cfg_idx] <= cfg_wdata;
      end
      if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          out_v_r <= 1'b1;
          out_r <= out_nxt;
          if (!cmd_r.is_tick) begin
            if (!cmd_r.reject_zero && count_r[0] != CW'(mlfq_pkg::QUEUE_DEPTH)) begin
              // Preemption rotates the running head to the tail of its own level.
              if (run_v_r && run_lvl_r != '0) begin
                qmem_r[{lvl_r, QW'(head_r[lvl_r] + QW'(count_r[lvl_r]))}] <= qrd_r;
                head_r[lvl_r] <= head_r[lvl_r] + 1'b1;
                run_v_r <= 1'b0;
              end
              rsvc_r[cmd_r.pid] <= cmd_r.service;
              rslice_r[cmd_r.pid] <= '0;
              qmem_r[{LW'(0), tail0}] <= cmd_r.pid;
              count_r[0] <= count_r[0] + 1'b1;
            end
          end else begin
            time_r <= time_r + 32'd1;
            if (any_r) begin
              if (sv <= 16'd1) begin
                rsvc_r[p] <= '0;
                rslice_r[p] <= '0;
                head_r[lvl_r] <= head_r[lvl_r] + 1'b1;
                count_r[lvl_r] <= count_r[lvl_r] - 1'b1;
                run_v_r <= 1'b0;
                done_cnt_r <= done_cnt_r + 5'd1;
              end else begin
                rsvc_r[p] <= sv - 16'd1;
                if (sl_dec == 8'd0) begin
                  rslice_r[p] <= '0;
                  run_v_r <= 1'b0;
                  head_r[lvl_r] <= head_r[lvl_r] + 1'b1;
                  if (dst == lvl_r) begin
                    // Pop and push on the same level: count is unchanged.
                    qmem_r[{lvl_r, QW'(head_r[lvl_r] + QW'(count_r[lvl_r]))}] <= p;
                  end else begin
                    count_r[lvl_r] <= count_r[lvl_r] - 1'b1;
                    qmem_r[{dst, QW'(head_r[dst] + QW'(count_r[dst]))}] <= p;
                    count_r[dst] <= count_r[dst] + 1'b1;
                  end
                end else begin
                  rslice_r[p] <= sl_dec;
                  run_v_r <= 1'b1;
                  run_lvl_r <= lvl_r;
                end
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/mlfq_preemptive_scheduler.sv
// Channel  | Direction | Ports
// input    | in        | in_valid, in_stall, in_data (kind, new_id, service_time)
// result   | out       | out_valid, out_stall, out_data (status .. preempted)
// config   | in        | cfg_we, cfg_idx, cfg_wdata
//
// In the execution unit each item first reads the head entry of the queue
// memory, then updates queues and counters and registers the result. A
// two-entry command queue decouples the input from execution. Reset is
// synchronous and active low; it restores the slice registers and empties
// all queues. A stalled output holds the next item in the queue.
module mlfq_preemptive_scheduler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mlfq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mlfq_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [7:0]           cfg_wdata
);

  logic           cmd_valid;
  logic           cmd_pop;
  mlfq_pkg::cmd_t cmd;

  // Front end: captures and classifies each transfer into a command.
  mlfq_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
  );

  // Back end: executes arrivals and ticks against the queue state.
  mlfq_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule
